### sv/vfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfr_pkg
// Shared types and constants of the velocity frame receiver.
// ----------------------------------------------------------------------------
package vfr_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int CRC_BYTES   = 14;
    localparam int POS_W       = 5;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    // register indexes
    localparam logic [2:0] REG_HEADER_FIRST  = 3'd0;
    localparam logic [2:0] REG_HEADER_SECOND = 3'd1;
    localparam logic [2:0] REG_TAIL_FIRST    = 3'd2;
    localparam logic [2:0] REG_TAIL_SECOND   = 3'd3;
    localparam logic [2:0] REG_LIMIT_FORWARD = 3'd4;
    localparam logic [2:0] REG_LIMIT_LATERAL = 3'd5;
    localparam logic [2:0] REG_LIMIT_TURN    = 3'd6;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd7;

    // event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_ACCEPT  = 2'd1;
    localparam logic [1:0] EV_REJECT  = 2'd2;
    localparam logic [1:0] EV_TIMEOUT = 2'd3;

    typedef struct packed {
        logic [7:0]  header_first;
        logic [7:0]  header_second;
        logic [7:0]  tail_first;
        logic [7:0]  tail_second;
        logic [30:0] limit_forward;
        logic [30:0] limit_lateral;
        logic [30:0] limit_turn;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [31:0] forward_speed;
        logic [31:0] lateral_speed;
        logic [31:0] turn_rate;
        logic        nav_active;
        logic [1:0]  event_res;
    } result_t;

    // one byte through the reflected CRC-16
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // clamp magnitude to limit, NaN passes
    function automatic logic [31:0] clamp_single(input logic [31:0] v, input logic [30:0] lim);
        logic [30:0] mag;
        mag = v[30:0];
        if (lim > 31'h7F800000 || mag > 31'h7F800000)
            return v;
        if (mag > lim)
            return {v[31], lim};
        return v;
    endfunction

endpackage
`default_nettype wire

### sv/vfr_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfr_cfg_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module vfr_cfg_regs
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_valid,
    output      logic           cfg_ready,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [31:0]    cfg_data,
    output      vfr_pkg::cfg_t  cfg
);

    vfr_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first  <= 8'hA5;
            cfg_reg.header_second <= 8'h5A;
            cfg_reg.tail_first    <= 8'h0D;
            cfg_reg.tail_second   <= 8'h0A;
            cfg_reg.limit_forward <= 31'h40000000;
            cfg_reg.limit_lateral <= 31'h40000000;
            cfg_reg.limit_turn    <= 31'h40400000;
            cfg_reg.timeout_ticks <= 16'd100;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                vfr_pkg::REG_HEADER_FIRST:  cfg_reg.header_first  <= cfg_data[7:0];
                vfr_pkg::REG_HEADER_SECOND: cfg_reg.header_second <= cfg_data[7:0];
                vfr_pkg::REG_TAIL_FIRST:    cfg_reg.tail_first    <= cfg_data[7:0];
                vfr_pkg::REG_TAIL_SECOND:   cfg_reg.tail_second   <= cfg_data[7:0];
                vfr_pkg::REG_LIMIT_FORWARD: cfg_reg.limit_forward <= cfg_data[30:0];
                vfr_pkg::REG_LIMIT_LATERAL: cfg_reg.limit_lateral <= cfg_data[30:0];
                vfr_pkg::REG_LIMIT_TURN:    cfg_reg.limit_turn    <= cfg_data[30:0];
                vfr_pkg::REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/vfr_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfr_core
// Frame parser, CRC, clamp and timeout; one word per cycle while step is high.
// ----------------------------------------------------------------------------
module vfr_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             command,
    input  wire logic [7:0]       data_byte,
    input  wire vfr_pkg::cfg_t    cfg,
    output      vfr_pkg::result_t res
);

    logic [vfr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]  store_reg [vfr_pkg::FRAME_BYTES];
    logic [15:0] crc_reg, crc_next;
    logic [31:0] fwd_reg, fwd_next, lat_reg, lat_next, turn_reg, turn_next;
    logic        act_reg, act_next;
    logic [15:0] ela_reg, ela_next;
    logic [1:0]  ev;
    logic        wr_en;
    logic [31:0] w_fwd, w_lat, w_turn;
    logic        ok;

    // frame words; last tail byte is still on the input
    assign w_fwd  = {store_reg[5], store_reg[4], store_reg[3], store_reg[2]};
    assign w_lat  = {store_reg[9], store_reg[8], store_reg[7], store_reg[6]};
    assign w_turn = {store_reg[13], store_reg[12], store_reg[11], store_reg[10]};
    assign ok = store_reg[0] == cfg.header_first && store_reg[1] == cfg.header_second
             && store_reg[16] == cfg.tail_first && data_byte == cfg.tail_second
             && {store_reg[15], store_reg[14]} == crc_reg;

    // next state
    always_comb
    begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        fwd_next  = fwd_reg;
        lat_next  = lat_reg;
        turn_next = turn_reg;
        act_next  = act_reg;
        ela_next  = ela_reg;
        ev        = vfr_pkg::EV_NONE;
        wr_en     = 1'b0;
        if (command)
        begin
            if (ela_reg != 16'hFFFF)
                ela_next = ela_reg + 16'd1;
            if (act_reg && ela_reg >= cfg.timeout_ticks)
            begin
                fwd_next  = '0;
                lat_next  = '0;
                turn_next = '0;
                act_next  = 1'b0;
                ev        = vfr_pkg::EV_TIMEOUT;
            end
        end
        else if (pos_reg == 0)
        begin
            if (data_byte == cfg.header_first)
            begin
                wr_en    = 1'b1;
                crc_next = vfr_pkg::crc_feed(16'h0000, data_byte);
                pos_next = 5'd1;
            end
        end
        else if (pos_reg == 5'd1)
        begin
            if (data_byte == cfg.header_second)
            begin
                wr_en    = 1'b1;
                crc_next = vfr_pkg::crc_feed(crc_reg, data_byte);
                pos_next = 5'd2;
            end
            else
                pos_next = '0;
        end
        else if (pos_reg >= 5'(vfr_pkg::FRAME_BYTES))
            pos_next = '0;
        else
        begin
            wr_en = 1'b1;
            if (pos_reg < 5'(vfr_pkg::CRC_BYTES))
                crc_next = vfr_pkg::crc_feed(crc_reg, data_byte);
            pos_next = pos_reg + 5'd1;
            if (pos_reg == 5'(vfr_pkg::FRAME_BYTES - 1))
            begin
                pos_next = '0;
                if (ok)
                begin
                    fwd_next  = vfr_pkg::clamp_single(w_fwd, cfg.limit_forward);
                    lat_next  = vfr_pkg::clamp_single(w_lat, cfg.limit_lateral);
                    turn_next = vfr_pkg::clamp_single(w_turn, cfg.limit_turn);
                    act_next  = 1'b1;
                    ela_next  = '0;
                    ev        = vfr_pkg::EV_ACCEPT;
                end
                else
                    ev = vfr_pkg::EV_REJECT;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            crc_reg  <= '0;
            fwd_reg  <= '0;
            lat_reg  <= '0;
            turn_reg <= '0;
            act_reg  <= 1'b0;
            ela_reg  <= '0;
            res      <= '0;
        end
        else if (step)
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            fwd_reg  <= fwd_next;
            lat_reg  <= lat_next;
            turn_reg <= turn_next;
            act_reg  <= act_next;
            ela_reg  <= ela_next;
            res      <= '{fwd_next, lat_next, turn_next, act_next, ev};
        end
    end

    // frame byte store
    always_ff @(posedge clk)
    begin
        if (step && wr_en && pos_reg < 5'(vfr_pkg::FRAME_BYTES))
            store_reg[pos_reg] <= data_byte;
    end

endmodule
`default_nettype wire

### sv/velocity_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// velocity_frame_receiver
// The result word of an accepted word is registered and shown in the next cycle.
// Throughput: one word per cycle while the output is not stalled; the result register frees as it is taken.
// The frame state and result register update together in a single pass.
// Reset (rst_n, async, low): hunt restarts, velocities zero, mode clear,
// registers to defaults.
// ----------------------------------------------------------------------------
module velocity_frame_receiver
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tuser,   // command
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [95:0] m_axis_tdata,   // forward_speed, lateral_speed, turn_rate
    output      logic [2:0]  m_axis_tuser,   // nav_active, event_res[1:0]
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    vfr_pkg::cfg_t    cfg;
    vfr_pkg::result_t res;
    logic             step;
    logic             valid_reg;

    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    vfr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vfr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .command   (s_axis_tuser),
        .data_byte (s_axis_tdata),
        .cfg       (cfg),
        .res       (res)
    );

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (s_axis_tready)
            valid_reg <= s_axis_tvalid;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {res.turn_rate, res.lateral_speed, res.forward_speed};
    assign m_axis_tuser  = {res.event_res, res.nav_active};

endmodule
`default_nettype wire
